// ===== rtl/phd_pkg.sv =====
// ----------------------------------------------------------------------------
// phd_pkg: shared definitions for the pairwise Hamming divergence block
// Field widths, register indexes, result codes, controller states and the
// command/status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package phd_pkg;

    // Default store dimensions
    localparam int DEF_MAX_TAXA   = 16;
    localparam int DEF_MAX_LENGTH = 1024;

    // Fixed field widths
    localparam int TAXON_W     = 4;
    localparam int POSITION_W  = 10;
    localparam int SYMBOL_W    = 8;
    localparam int TAXA_CFG_W  = 5;
    localparam int LEN_CFG_W   = 11;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 1;
    localparam int FRAC_W      = 16;
    localparam int DIST_OUT_W  = 11;
    localparam int TOTAL_OUT_W = 17;
    localparam int DIV_OUT_W   = 17;
    localparam int STATUS_W    = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TAXA_COUNT      = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SEQUENCE_LENGTH = 1'd1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_EMPTY    = 2'd1,
        STATUS_FEW_TAXA = 2'd2,
        STATUS_ZERO_LEN = 2'd3
    } result_status_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_WALK,
        S_DRAIN,
        S_START_MIN,
        S_WAIT_MIN,
        S_START_AVG,
        S_WAIT_AVG,
        S_OUTPUT
    } phd_state_t;

    // Controller to datapath
    typedef struct packed {
        logic store;        // input transaction accepted
        logic init;         // latch status code, clear accumulators
        logic walk;         // issue one column read for the current pair
        logic div_start;    // launch the shared divider
        logic div_sel_avg;  // 1: average divergence, 0: minimum divergence
        logic cap_min;      // capture quotient as minimum divergence
        logic cap_avg;      // capture quotient as average divergence
        logic load_out;     // move results into the output register
    } phd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        result_status_t code;  // status of the current request
        logic walk_last;       // current read is the final column of the final pair
        logic pipe_busy;       // read data still in flight
        logic div_busy;        // divider iterating
        logic out_free;        // output register can take a result
    } phd_stat_t;

endpackage

// ===== rtl/phd_div.sv =====
// ----------------------------------------------------------------------------
// phd_div: restoring unsigned divider
// One quotient bit per cycle, one for each dividend bit. Quotient valid
// once busy falls, and held until the next start.
// ----------------------------------------------------------------------------
module phd_div #(
    parameter int DVD_W = 34,
    parameter int DVS_W = 18
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVS_W:0]   rem_reg;
    logic [DVS_W:0]   rem_next;
    logic [DVD_W-1:0] quo_reg;
    logic [DVD_W-1:0] quo_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [DVS_W:0]   shifted;
    logic             q_bit;

    // One restoring step
    always_comb
    begin
        shifted  = {rem_reg[DVS_W-1:0], quo_reg[DVD_W-1]};
        q_bit    = (shifted >= {1'b0, dvs_reg});
        rem_next = q_bit ? (shifted - {1'b0, dvs_reg}) : shifted;
        quo_next = {quo_reg[DVD_W-2:0], q_bit};
    end

    // Iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DVD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Remainder / quotient shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/phd_ctrl.sv =====
// ----------------------------------------------------------------------------
// phd_ctrl: sequencing controller
// Accepts symbols while idle; on the last symbol runs the status check and, on OK,
// the pairwise column walk and both divisions; then the output register hand-off.
// ----------------------------------------------------------------------------
module phd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               last,
    input  phd_pkg::phd_stat_t stat,
    output logic               in_stall,
    output phd_pkg::phd_cmd_t  cmd
);

    phd_pkg::phd_state_t state_reg;
    phd_pkg::phd_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= phd_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            phd_pkg::S_IDLE:
            begin
                if (in_valid && last)
                begin
                    state_next = phd_pkg::S_CHECK;
                end
            end
            phd_pkg::S_CHECK:
            begin
                if (stat.code == phd_pkg::STATUS_OK)
                begin
                    state_next = phd_pkg::S_WALK;
                end
                else
                begin
                    state_next = phd_pkg::S_OUTPUT;
                end
            end
            phd_pkg::S_WALK:
            begin
                if (stat.walk_last)
                begin
                    state_next = phd_pkg::S_DRAIN;
                end
            end
            phd_pkg::S_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = phd_pkg::S_START_MIN;
                end
            end
            phd_pkg::S_START_MIN:
            begin
                state_next = phd_pkg::S_WAIT_MIN;
            end
            phd_pkg::S_WAIT_MIN:
            begin
                if (!stat.div_busy)
                begin
                    state_next = phd_pkg::S_START_AVG;
                end
            end
            phd_pkg::S_START_AVG:
            begin
                state_next = phd_pkg::S_WAIT_AVG;
            end
            phd_pkg::S_WAIT_AVG:
            begin
                if (!stat.div_busy)
                begin
                    state_next = phd_pkg::S_OUTPUT;
                end
            end
            phd_pkg::S_OUTPUT:
            begin
                if (stat.out_free)
                begin
                    state_next = phd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = phd_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd         = '0;
        in_stall    = (state_reg != phd_pkg::S_IDLE);
        unique case (state_reg)
            phd_pkg::S_IDLE:
            begin
                cmd.store = in_valid;
            end
            phd_pkg::S_CHECK:
            begin
                cmd.init = 1'b1;
            end
            phd_pkg::S_WALK:
            begin
                cmd.walk = 1'b1;
            end
            phd_pkg::S_START_MIN:
            begin
                cmd.div_start = 1'b1;
            end
            phd_pkg::S_WAIT_MIN:
            begin
                cmd.cap_min = !stat.div_busy;
            end
            phd_pkg::S_START_AVG:
            begin
                cmd.div_start   = 1'b1;
                cmd.div_sel_avg = 1'b1;
            end
            phd_pkg::S_WAIT_AVG:
            begin
                cmd.cap_avg = !stat.div_busy;
            end
            phd_pkg::S_OUTPUT:
            begin
                cmd.load_out = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/phd_datapath.sv =====
// ----------------------------------------------------------------------------
// phd_datapath: symbol store, pair walk, accumulators and result registers
// Two-read-port symbol memory, column counters, Hamming accumulation,
// shared divider and the output register.
// ----------------------------------------------------------------------------
module phd_datapath #(
    parameter int MAX_TAXA   = phd_pkg::DEF_MAX_TAXA,
    parameter int MAX_LENGTH = phd_pkg::DEF_MAX_LENGTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [phd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [phd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [phd_pkg::TAXON_W-1:0]        taxon,
    input  logic [phd_pkg::POSITION_W-1:0]     position,
    input  logic [phd_pkg::SYMBOL_W-1:0]       symbol,
    input  logic                               out_stall,
    input  phd_pkg::phd_cmd_t                  cmd,
    output phd_pkg::phd_stat_t                 stat,
    output logic                               out_valid,
    output logic [phd_pkg::DIST_OUT_W-1:0]     min_distance,
    output logic [phd_pkg::TOTAL_OUT_W-1:0]    total_distance,
    output logic [phd_pkg::DIV_OUT_W-1:0]      min_divergence,
    output logic [phd_pkg::DIV_OUT_W-1:0]      avg_divergence,
    output logic [phd_pkg::STATUS_W-1:0]       status
);

    localparam int TAXA_W    = $clog2(MAX_TAXA);
    localparam int LEN_W     = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int ADDR_W    = TAXA_W + LEN_W;
    localparam int DEPTH     = 1 << ADDR_W;
    localparam int CNT_W     = $clog2(MAX_TAXA + 1);
    localparam int MAX_PAIRS = MAX_TAXA * (MAX_TAXA - 1) / 2;
    localparam int PAIR_W    = $clog2(MAX_PAIRS + 1);
    localparam int DIST_W    = phd_pkg::LEN_CFG_W;
    localparam int TOT_W     = DIST_W + PAIR_W;
    localparam int DVD_W     = TOT_W + phd_pkg::FRAC_W;
    localparam int DVS_W     = DIST_W + PAIR_W;
    localparam int CMP_W     = DIST_W + LEN_W;
    localparam int SYM_W     = phd_pkg::SYMBOL_W;

    // Configuration registers
    logic [phd_pkg::TAXA_CFG_W-1:0] taxa_count_reg;
    logic [phd_pkg::LEN_CFG_W-1:0]  seq_len_reg;
    logic                           loaded_reg;

    // Symbol store
    logic [SYM_W-1:0]  store_mem [DEPTH];
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic              in_range;
    logic [SYM_W-1:0]  rd_a_reg;
    logic [SYM_W-1:0]  rd_b_reg;
    logic              rd_valid_reg;
    logic              rd_end_reg;

    // Walk counters
    logic [TAXA_W-1:0] i_reg;
    logic [TAXA_W-1:0] j_reg;
    logic [LEN_W-1:0]  k_reg;
    logic              k_end;
    logic              j_end;
    logic              i_last;

    // Effective sizes and status
    logic [CNT_W-1:0]        n_sat;
    logic [DIST_W-1:0]       len_sat;
    logic [2*CNT_W-1:0]      n_prod;
    logic [PAIR_W-1:0]       pairs_reg;
    phd_pkg::result_status_t code;
    phd_pkg::result_status_t code_reg;

    // Accumulators
    logic [DIST_W-1:0] dacc_reg;
    logic [DIST_W-1:0] d_sum;
    logic [DIST_W-1:0] min_reg;
    logic [TOT_W-1:0]  total_reg;
    logic              have_min_reg;

    // Divider
    logic [DVD_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    logic [DVD_W-1:0] div_quotient;
    logic             div_busy;
    logic [phd_pkg::DIV_OUT_W-1:0] min_div_reg;
    logic [phd_pkg::DIV_OUT_W-1:0] avg_div_reg;

    // Output register
    logic                                 out_valid_reg;
    logic [phd_pkg::DIST_OUT_W-1:0]       out_min_reg;
    logic [phd_pkg::TOTAL_OUT_W-1:0]      out_total_reg;
    logic [phd_pkg::DIV_OUT_W-1:0]        out_min_div_reg;
    logic [phd_pkg::DIV_OUT_W-1:0]        out_avg_div_reg;
    logic [phd_pkg::STATUS_W-1:0]         out_status_reg;
    logic [TOT_W+phd_pkg::TOTAL_OUT_W-1:0] total_ext;
    logic                                 out_free;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taxa_count_reg <= '0;
            seq_len_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                phd_pkg::REG_TAXA_COUNT:
                begin
                    taxa_count_reg <= cfg_data[phd_pkg::TAXA_CFG_W-1:0];
                end
                phd_pkg::REG_SEQUENCE_LENGTH:
                begin
                    seq_len_reg <= cfg_data[phd_pkg::LEN_CFG_W-1:0];
                end
                default:
                begin
                    seq_len_reg <= seq_len_reg;
                end
            endcase
        end
    end

    // Saturated sizes and request status
    always_comb
    begin
        n_sat   = (32'(taxa_count_reg) > MAX_TAXA) ? CNT_W'(MAX_TAXA)
                                                   : CNT_W'(taxa_count_reg);
        len_sat = (32'(seq_len_reg) > MAX_LENGTH) ? DIST_W'(MAX_LENGTH) : seq_len_reg;
        n_prod  = {CNT_W'(0), n_sat} * {CNT_W'(0), n_sat - CNT_W'(1)};
        priority if (!loaded_reg)
        begin
            code = phd_pkg::STATUS_EMPTY;
        end
        else if (n_sat < CNT_W'(2))
        begin
            code = phd_pkg::STATUS_FEW_TAXA;
        end
        else if (len_sat == '0)
        begin
            code = phd_pkg::STATUS_ZERO_LEN;
        end
        else
        begin
            code = phd_pkg::STATUS_OK;
        end
    end

    // Store addressing
    assign in_range  = (32'(taxon) < MAX_TAXA) && (32'(position) < MAX_LENGTH);
    assign wr_addr   = {TAXA_W'(taxon), LEN_W'(position)};
    assign rd_addr_a = {i_reg, k_reg};
    assign rd_addr_b = {j_reg, k_reg};

    // Loaded flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= 1'b0;
        end
        else if (cmd.store && in_range)
        begin
            loaded_reg <= 1'b1;
        end
    end

    // Symbol memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (cmd.store && in_range)
        begin
            store_mem[wr_addr] <= symbol;
        end
        rd_a_reg <= store_mem[rd_addr_a];
        rd_b_reg <= store_mem[rd_addr_b];
    end

    // Walk end conditions
    assign k_end  = (CMP_W'(k_reg) + CMP_W'(1)) == CMP_W'(len_sat);
    assign j_end  = ((CNT_W+1)'(j_reg) + (CNT_W+1)'(1)) == (CNT_W+1)'(n_sat);
    assign i_last = ((CNT_W+1)'(i_reg) + (CNT_W+1)'(2)) == (CNT_W+1)'(n_sat);

    // Pair and column counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            rd_valid_reg <= 1'b0;
            rd_end_reg   <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.walk;
            rd_end_reg   <= k_end;
            if (cmd.init)
            begin
                i_reg <= '0;
                j_reg <= TAXA_W'(1);
                k_reg <= '0;
            end
            else if (cmd.walk)
            begin
                if (k_end)
                begin
                    k_reg <= '0;
                    if (j_end)
                    begin
                        i_reg <= i_reg + TAXA_W'(1);
                        j_reg <= i_reg + TAXA_W'(2);
                    end
                    else
                    begin
                        j_reg <= j_reg + TAXA_W'(1);
                    end
                end
                else
                begin
                    k_reg <= k_reg + LEN_W'(1);
                end
            end
        end
    end

    // Hamming accumulation and pair fold
    assign d_sum = dacc_reg + DIST_W'(rd_a_reg != rd_b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dacc_reg     <= '0;
            min_reg      <= '0;
            total_reg    <= '0;
            have_min_reg <= 1'b0;
        end
        else if (cmd.init)
        begin
            dacc_reg     <= '0;
            min_reg      <= '0;
            total_reg    <= '0;
            have_min_reg <= 1'b0;
        end
        else if (rd_valid_reg)
        begin
            if (rd_end_reg)
            begin
                dacc_reg     <= '0;
                total_reg    <= total_reg + TOT_W'(d_sum);
                have_min_reg <= 1'b1;
                if (!have_min_reg || (d_sum < min_reg))
                begin
                    min_reg <= d_sum;
                end
            end
            else
            begin
                dacc_reg <= d_sum;
            end
        end
    end

    // Pair count, status code and divergence results
    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            pairs_reg   <= PAIR_W'(n_prod >> 1);
            code_reg    <= code;
            min_div_reg <= '0;
            avg_div_reg <= '0;
        end
        else
        begin
            if (cmd.cap_min)
            begin
                min_div_reg <= div_quotient[phd_pkg::DIV_OUT_W-1:0];
            end
            if (cmd.cap_avg)
            begin
                avg_div_reg <= div_quotient[phd_pkg::DIV_OUT_W-1:0];
            end
        end
    end

    // Shared divider operands
    always_comb
    begin
        if (cmd.div_sel_avg)
        begin
            div_dividend = DVD_W'({total_reg, phd_pkg::FRAC_W'(0)});
            div_divisor  = DVS_W'(len_sat) * DVS_W'(pairs_reg);
        end
        else
        begin
            div_dividend = DVD_W'({min_reg, phd_pkg::FRAC_W'(0)});
            div_divisor  = DVS_W'(len_sat);
        end
    end

    phd_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    // Output register
    assign out_free  = !out_valid_reg || !out_stall;
    assign total_ext = (TOT_W+phd_pkg::TOTAL_OUT_W)'(total_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_min_reg     <= min_reg;
            out_total_reg   <= total_ext[phd_pkg::TOTAL_OUT_W-1:0];
            out_min_div_reg <= min_div_reg;
            out_avg_div_reg <= avg_div_reg;
            out_status_reg  <= code_reg;
        end
    end

    // Status back to the controller
    always_comb
    begin
        stat           = '0;
        stat.code      = code;
        stat.walk_last = i_last && j_end && k_end;
        stat.pipe_busy = rd_valid_reg;
        stat.div_busy  = div_busy;
        stat.out_free  = out_free;
    end

    assign out_valid      = out_valid_reg;
    assign min_distance   = out_min_reg;
    assign total_distance = out_total_reg;
    assign min_divergence = out_min_div_reg;
    assign avg_divergence = out_avg_div_reg;
    assign status         = out_status_reg;

endmodule

// ===== rtl/pairwise_hamming_divergence.sv =====
// ----------------------------------------------------------------------------
// pairwise_hamming_divergence: pairwise Hamming distance over a loaded matrix
// Stores an aligned symbol matrix and reports minimum/total pair distance
// and the minimum/average divergence as unsigned Q1.16 fractions.
// ----------------------------------------------------------------------------
// Usage:
//   Configure taxa_count (index 0) and sequence_length (index 1) through the
//   write port while the block is idle. Symbols arrive on the input channel
//   (valid/stall), one transaction per cycle while idle; each writes one entry
//   of the store addressed by taxon and position.
//   A transaction with last set starts the computation: one column of one
//   pair is compared per cycle through the two read ports of the store, and
//   both divergences come from the shared one-bit-per-cycle divider of DVD_W
//   bits, where DVD_W = 11 + clog2(pairs_max + 1) + 16 (34 at the default
//   sizes). Error cases (nothing loaded, fewer than two taxa, zero length)
//   skip the walk and the divisions and go straight to the output register.
//   in_stall is high from the cycle after a last transaction until the
//   result is placed in the output register.
//   The result stays in the output register while out_stall is high; the
//   input side keeps accepting symbols meanwhile.
//   Reset clears the configuration, the loaded flag and all control state;
//   the store contents are undefined until written.
// ----------------------------------------------------------------------------
module pairwise_hamming_divergence #(
    parameter int MAX_TAXA   = phd_pkg::DEF_MAX_TAXA,
    parameter int MAX_LENGTH = phd_pkg::DEF_MAX_LENGTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [phd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [phd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [phd_pkg::TAXON_W-1:0]        taxon,
    input  logic [phd_pkg::POSITION_W-1:0]     position,
    input  logic [phd_pkg::SYMBOL_W-1:0]       symbol,
    input  logic                               last,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [phd_pkg::DIST_OUT_W-1:0]     min_distance,
    output logic [phd_pkg::TOTAL_OUT_W-1:0]    total_distance,
    output logic [phd_pkg::DIV_OUT_W-1:0]      min_divergence,
    output logic [phd_pkg::DIV_OUT_W-1:0]      avg_divergence,
    output logic [phd_pkg::STATUS_W-1:0]       status
);

    phd_pkg::phd_cmd_t  cmd;
    phd_pkg::phd_stat_t stat;

    // Controller
    phd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .last     (last),
        .stat     (stat),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    // Datapath
    phd_datapath #(
        .MAX_TAXA   (MAX_TAXA),
        .MAX_LENGTH (MAX_LENGTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .taxon          (taxon),
        .position       (position),
        .symbol         (symbol),
        .out_stall      (out_stall),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (out_valid),
        .min_distance   (min_distance),
        .total_distance (total_distance),
        .min_divergence (min_divergence),
        .avg_divergence (avg_divergence),
        .status         (status)
    );

    // A last transaction always starts a computation
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && last) |=> in_stall)
    else $error("last transaction did not start a computation");

    // Error results carry zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != phd_pkg::STATUS_OK)) |->
        ((min_distance == '0) && (total_distance == '0) &&
         (min_divergence == '0) && (avg_divergence == '0)))
    else $error("error result with nonzero fields");

    // Divergences never exceed 1.0
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((min_divergence <= 17'd65536) && (avg_divergence <= 17'd65536)))
    else $error("divergence above 1.0");

    // Store writes only while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> !in_stall)
    else $error("store write while busy");

endmodule

// ===== sim/tb_pairwise_hamming_divergence.sv =====
// ----------------------------------------------------------------------------
// tb_pairwise_hamming_divergence: self-checking bench for the divergence block
// Loads symbol matrices over the valid/stall input channel and keeps a local
// copy of the store and registers. Each last transaction gets a predicted
// result: minimum and total pair distance plus both Q1.16 divergences.
// Output transactions are compared field by field under several idle and
// stall patterns. The sequence covers error codes, register saturation,
// extreme fields and random well-formed matrices.
// ----------------------------------------------------------------------------
module tb_pairwise_hamming_divergence;

    localparam int NUM_TAXA      = phd_pkg::DEF_MAX_TAXA;
    localparam int NUM_COLS      = phd_pkg::DEF_MAX_LENGTH;
    localparam int HALF_PERIOD   = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 200;
    localparam int PHASE_ITEMS   = 460;

    typedef struct {
        logic [phd_pkg::TAXON_W-1:0]    taxon;
        logic [phd_pkg::POSITION_W-1:0] position;
        logic [phd_pkg::SYMBOL_W-1:0]   symbol;
        logic                           last;
    } symbol_txn_t;

    typedef struct {
        logic [phd_pkg::DIST_OUT_W-1:0]  min_distance;
        logic [phd_pkg::TOTAL_OUT_W-1:0] total_distance;
        logic [phd_pkg::DIV_OUT_W-1:0]   min_divergence;
        logic [phd_pkg::DIV_OUT_W-1:0]   avg_divergence;
        phd_pkg::result_status_t         status;
    } divergence_result_t;

    // DUT ports
    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [phd_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [phd_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    logic [phd_pkg::TAXON_W-1:0]     taxon;
    logic [phd_pkg::POSITION_W-1:0]  position;
    logic [phd_pkg::SYMBOL_W-1:0]    symbol;
    logic                            last;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [phd_pkg::DIST_OUT_W-1:0]  min_distance;
    logic [phd_pkg::TOTAL_OUT_W-1:0] total_distance;
    logic [phd_pkg::DIV_OUT_W-1:0]   min_divergence;
    logic [phd_pkg::DIV_OUT_W-1:0]   avg_divergence;
    logic [phd_pkg::STATUS_W-1:0]    status;

    // Local copy of the block state
    logic [phd_pkg::SYMBOL_W-1:0]   symbol_mem [NUM_TAXA][NUM_COLS];
    bit                             written_map [NUM_TAXA][NUM_COLS];
    bit                             matrix_loaded = 1'b0;
    logic [phd_pkg::TAXA_CFG_W-1:0] cfg_taxa = '0;
    logic [phd_pkg::LEN_CFG_W-1:0]  cfg_length = '0;

    divergence_result_t pending_results[$];
    int                 mismatch_count = 0;
    int                 sent_count = 0;
    int                 idle_pct = 0;
    int                 stall_pct = 0;

    pairwise_hamming_divergence u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .taxon          (taxon),
        .position       (position),
        .symbol         (symbol),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .min_distance   (min_distance),
        .total_distance (total_distance),
        .min_divergence (min_divergence),
        .avg_divergence (avg_divergence),
        .status         (status)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Receiver back-pressure
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Result checker: each output transaction against the oldest prediction
    always @(posedge clk)
    begin : result_check
        divergence_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction, status %0d", status);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (min_distance !== want.min_distance)
                begin
                    $error("min_distance: expected %0d, got %0d",
                           want.min_distance, min_distance);
                    mismatch_count++;
                end
                if (total_distance !== want.total_distance)
                begin
                    $error("total_distance: expected %0d, got %0d",
                           want.total_distance, total_distance);
                    mismatch_count++;
                end
                if (min_divergence !== want.min_divergence)
                begin
                    $error("min_divergence: expected %0d, got %0d",
                           want.min_divergence, min_divergence);
                    mismatch_count++;
                end
                if (avg_divergence !== want.avg_divergence)
                begin
                    $error("avg_divergence: expected %0d, got %0d",
                           want.avg_divergence, avg_divergence);
                    mismatch_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    mismatch_count++;
                end
            end
        end
    end

    // Register values clamp to the store size
    function automatic int saturate_rows(input int value);
        return (value > NUM_TAXA) ? NUM_TAXA : value;
    endfunction

    function automatic int saturate_cols(input int value);
        return (value > NUM_COLS) ? NUM_COLS : value;
    endfunction

    // True when every entry the pair walk would read has been written
    function automatic bit region_ready(input int rows, input int cols);
        for (int i = 0; i < rows; i++)
        begin
            for (int k = 0; k < cols; k++)
            begin
                if (!written_map[i][k])
                begin
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    // Pairwise distances and divergences over the current store contents
    function automatic divergence_result_t predict_divergence();
        divergence_result_t res;
        longint unsigned    n_rows;
        longint unsigned    n_cols;
        longint unsigned    pairs;
        longint unsigned    pair_dist;
        longint unsigned    min_d;
        longint unsigned    total;
        longint unsigned    min_div;
        longint unsigned    avg_div;
        bit                 have_min;
        n_rows   = saturate_rows(cfg_taxa);
        n_cols   = saturate_cols(cfg_length);
        min_d    = 0;
        total    = 0;
        min_div  = 0;
        avg_div  = 0;
        have_min = 1'b0;
        // error checks in priority order; fields stay zero
        if (!matrix_loaded)
        begin
            res.status = phd_pkg::STATUS_EMPTY;
        end
        else if (n_rows < 2)
        begin
            res.status = phd_pkg::STATUS_FEW_TAXA;
        end
        else if (n_cols == 0)
        begin
            res.status = phd_pkg::STATUS_ZERO_LEN;
        end
        else
        begin
            res.status = phd_pkg::STATUS_OK;
            pairs = n_rows * (n_rows - 1) / 2;
            for (int i = 0; i < n_rows; i++)
            begin
                for (int j = i + 1; j < n_rows; j++)
                begin
                    pair_dist = 0;
                    for (int k = 0; k < n_cols; k++)
                    begin
                        if (symbol_mem[i][k] != symbol_mem[j][k])
                        begin
                            pair_dist++;
                        end
                    end
                    total += pair_dist;
                    if (!have_min || pair_dist < min_d)
                    begin
                        min_d    = pair_dist;
                        have_min = 1'b1;
                    end
                end
            end
            min_div = (min_d << phd_pkg::FRAC_W) / n_cols;
            avg_div = (total << phd_pkg::FRAC_W) / (n_cols * pairs);
        end
        res.min_distance   = phd_pkg::DIST_OUT_W'(min_d);
        res.total_distance = phd_pkg::TOTAL_OUT_W'(total);
        res.min_divergence = phd_pkg::DIV_OUT_W'(min_div);
        res.avg_divergence = phd_pkg::DIV_OUT_W'(avg_div);
        return res;
    endfunction

    // Apply one accepted transaction to the local state
    function automatic void record_symbol(input symbol_txn_t txn);
        // a 4-bit taxon and 10-bit position always land inside the store
        symbol_mem[txn.taxon][txn.position]  = txn.symbol;
        written_map[txn.taxon][txn.position] = 1'b1;
        matrix_loaded = 1'b1;
        if (txn.last)
        begin
            pending_results.insert(pending_results.size(), predict_divergence());
        end
    endfunction

    function automatic symbol_txn_t make_symbol(input int t, input int p, input int s,
                                                input bit is_last);
        symbol_txn_t txn;
        txn.taxon    = phd_pkg::TAXON_W'(t);
        txn.position = phd_pkg::POSITION_W'(p);
        txn.symbol   = phd_pkg::SYMBOL_W'(s);
        txn.last     = is_last;
        return txn;
    endfunction

    // Mostly nucleotide letters so that columns often agree
    function automatic logic [phd_pkg::SYMBOL_W-1:0] random_symbol();
        case ($urandom_range(4))
            0:       return 8'h41;
            1:       return 8'h43;
            2:       return 8'h47;
            3:       return 8'h54;
            default: return phd_pkg::SYMBOL_W'($urandom);
        endcase
    endfunction

    function automatic symbol_txn_t noise_symbol();
        return make_symbol($urandom, $urandom, $urandom, 1'b0);
    endfunction

    // Send one input transaction; returns at the falling edge after acceptance
    task automatic send_symbol(input symbol_txn_t txn);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        taxon    <= txn.taxon;
        position <= txn.position;
        symbol   <= txn.symbol;
        last     <= txn.last;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        record_symbol(txn);
        sent_count++;
        @(negedge clk);
    endtask

    // Drop valid, wait for all results, then let the block go quiet
    task automatic settle_block(input int extra);
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (extra) @(negedge clk);
    endtask

    // Write both registers; upper data bits of the taxa write are junk
    task automatic write_config(input int taxa_value, input int length_value);
        logic [phd_pkg::CFG_DATA_W-1:0] word;
        word = phd_pkg::CFG_DATA_W'($urandom);
        word[phd_pkg::TAXA_CFG_W-1:0] = phd_pkg::TAXA_CFG_W'(taxa_value);
        cfg_we     <= 1'b1;
        cfg_index  <= phd_pkg::REG_TAXA_COUNT;
        cfg_data   <= word;
        cfg_taxa   = phd_pkg::TAXA_CFG_W'(taxa_value);
        @(negedge clk);
        cfg_index  <= phd_pkg::REG_SEQUENCE_LENGTH;
        cfg_data   <= phd_pkg::CFG_DATA_W'(length_value);
        cfg_length = phd_pkg::LEN_CFG_W'(length_value);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Status codes, starting from reset register values. The first stored
    // symbol sets the loaded flag and every position is inside the store,
    // so the empty-matrix code is unreachable at the default sizes.
    task automatic test_error_status();
        send_symbol(make_symbol(15, 1023, 8'hFF, 1'b1));
        settle_block(SETTLE_CYCLES);
        write_config(1, 2047);
        send_symbol(make_symbol(0, 0, 8'h00, 1'b1));
        settle_block(SETTLE_CYCLES);
        write_config(2, 0);
        send_symbol(make_symbol(1, 0, 8'h5A, 1'b1));
        settle_block(SETTLE_CYCLES);
        write_config(31, 0);
        send_symbol(make_symbol(8, 512, 8'hA5, 1'b1));
        settle_block(SETTLE_CYCLES);
    endtask

    // Oversized taxa count clamps to 16; all taxa differ -> divergence of 1.0,
    // then an identical pair drives the minimum to zero
    task automatic test_distinct_columns();
        write_config(31, 1);
        for (int i = 0; i < NUM_TAXA; i++)
        begin
            send_symbol(make_symbol(i, 0, i * 17, i == NUM_TAXA - 1));
        end
        settle_block(SETTLE_CYCLES);
        write_config(3, 1);
        send_symbol(make_symbol(2, 0, 8'h00, 1'b1));
        settle_block(SETTLE_CYCLES);
    endtask

    // Random matrices: mostly fully loaded regions with random content,
    // some error configurations and stray writes
    task automatic test_random_matrices(input int sender_idle, input int receiver_stall,
                                        input int item_budget);
        symbol_txn_t                  round_items[$];
        symbol_txn_t                  held;
        logic [phd_pkg::SYMBOL_W-1:0] column_base [NUM_COLS];
        int                           start_count;
        int                           pick;
        int                           taxa_value;
        int                           length_value;
        int                           n_rows;
        int                           n_cols;
        int                           rewrite_pct;
        int                           swap_idx;
        idle_pct    = sender_idle;
        stall_pct   = receiver_stall;
        start_count = sent_count;
        while (sent_count - start_count < item_budget)
        begin
            round_items.delete();
            pick   = $urandom_range(99);
            n_rows = saturate_rows(cfg_taxa);
            n_cols = saturate_cols(cfg_length);
            if (pick < 10)
            begin
                // error configuration: too few taxa or zero length
                settle_block(SETTLE_CYCLES);
                if ($urandom_range(1))
                begin
                    write_config($urandom_range(1), $urandom_range(2047));
                end
                else
                begin
                    write_config($urandom_range(31, 2), 0);
                end
                repeat ($urandom_range(3))
                    round_items.insert(round_items.size(), noise_symbol());
                round_items.insert(round_items.size(), noise_symbol());
            end
            else
            begin
                if (pick >= 55 || n_rows < 2 || n_cols == 0)
                begin
                    // new matrix shape, mostly small
                    settle_block(SETTLE_CYCLES);
                    pick = $urandom_range(99);
                    if (pick < 60)
                        taxa_value = $urandom_range(4, 2);
                    else if (pick < 85)
                        taxa_value = $urandom_range(8, 5);
                    else if (pick < 95)
                        taxa_value = $urandom_range(16, 9);
                    else
                        taxa_value = $urandom_range(31, 17);
                    pick = $urandom_range(99);
                    if (pick < 70)
                        length_value = $urandom_range(8, 1);
                    else if (pick < 96)
                        length_value = $urandom_range(24, 9);
                    else
                        length_value = $urandom_range(2047, 1024);
                    if (length_value >= NUM_COLS &&
                        !region_ready(saturate_rows(taxa_value), NUM_COLS))
                    begin
                        length_value = $urandom_range(8, 1);
                    end
                    write_config(taxa_value, length_value);
                    n_rows = saturate_rows(cfg_taxa);
                    n_cols = saturate_cols(cfg_length);
                end
                // fill every missing entry, rewrite some of the others
                rewrite_pct = (n_cols > 64) ? 2 : 60;
                for (int k = 0; k < n_cols; k++)
                begin
                    column_base[k] = random_symbol();
                end
                for (int i = 0; i < n_rows; i++)
                begin
                    for (int k = 0; k < n_cols; k++)
                    begin
                        if (!written_map[i][k] || $urandom_range(99) < rewrite_pct)
                        begin
                            round_items.insert(round_items.size(), make_symbol(i, k,
                                ($urandom_range(99) < 75) ? column_base[k]
                                                          : random_symbol(), 1'b0));
                            if ($urandom_range(99) < 8)
                            begin
                                round_items.insert(round_items.size(), noise_symbol());
                            end
                        end
                    end
                end
                if (round_items.size() == 0)
                begin
                    round_items.insert(round_items.size(),
                                       make_symbol($urandom_range(n_rows - 1),
                                                   $urandom_range(n_cols - 1),
                                                   random_symbol(), 1'b0));
                end
            end
            // shuffle; the region stays complete at the final transaction
            for (int idx = round_items.size() - 1; idx > 0; idx--)
            begin
                swap_idx            = $urandom_range(idx);
                held                = round_items[idx];
                round_items[idx]    = round_items[swap_idx];
                round_items[swap_idx] = held;
            end
            round_items[round_items.size() - 1].last = 1'b1;
            foreach (round_items[idx])
            begin
                send_symbol(round_items[idx]);
            end
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = phd_pkg::REG_TAXA_COUNT;
        cfg_data  = '0;
        in_valid  = 1'b0;
        taxon     = '0;
        position  = '0;
        symbol    = '0;
        last      = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_error_status();
        test_distinct_columns();
        test_random_matrices(0, 0, PHASE_ITEMS);
        test_random_matrices(73, 0, PHASE_ITEMS);
        test_random_matrices(0, 73, PHASE_ITEMS);
        test_random_matrices(10, 10, PHASE_ITEMS);
        settle_block(END_CYCLES);

        if (mismatch_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #(64'd1_000_000_000);
        $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/phd_pkg.sv
rtl/phd_div.sv
rtl/phd_ctrl.sv
rtl/phd_datapath.sv
rtl/pairwise_hamming_divergence.sv
sim/tb_pairwise_hamming_divergence.sv
